// ===== hw/rtl/allpass_reverb_section_macros.svh =====
// assertion macros shared by the allpass reverb section rtl
// no dependencies; included by the modules that carry assertions
`ifndef ALLPASS_REVERB_SECTION_MACROS_SVH
`define ALLPASS_REVERB_SECTION_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ARV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ARV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/arv_pkg.sv =====
// shared types and constants of the allpass reverb section
// no dependencies; imported by controller, datapath and top level
package arv_pkg;

  // configuration register indexes and data width
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN    = 2'd2;

  // register widths and reset values
  localparam int unsigned DLEN_W = 12;
  localparam int unsigned GAIN_W = 16;
  localparam logic [DLEN_W-1:0]        DLEN_RESET = 12'd1440;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd29262;

  // multiplier operand a is 32 bits: holds the gain or 1 - g*g in q.30
  localparam int unsigned MUL_A_W = 32;
  localparam logic [MUL_A_W-1:0] ONE_Q30 = 32'h4000_0000;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GP,
    ST_W,
    ST_GX,
    ST_CD,
    ST_OUT
  } arv_state_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_G_PREV,
    MUL_G_G,
    MUL_G_X,
    MUL_C_DLY
  } arv_mul_op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        accept;
    logic        take_read;
    logic        write_w;
    logic        calc_c;
    logic        load_acc;
    logic        mul_en;
    arv_mul_op_t mul_op;
    logic        load_out;
  } arv_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic enable;
  } arv_sts_t;

endpackage

// ===== hw/rtl/arv_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module arv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hw/rtl/arv_ctrl.sv =====
// sequencer of the allpass reverb section: handshakes and step order
// depends on arv_pkg and the assertion macro header
`include "allpass_reverb_section_macros.svh"

module arv_ctrl
  import arv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  arv_sts_t sts,
  output arv_cmd_t cmd
);

  arv_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.enable ? ST_GP : ST_OUT;
        end
      end
      ST_GP:  state_nxt = ST_W;
      ST_W:   state_nxt = ST_GX;
      ST_GX:  state_nxt = ST_CD;
      ST_CD:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_G_PREV;
    unique case (state_r)
      ST_IDLE: cmd.accept = in_valid;
      ST_GP: begin
        cmd.take_read = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_op    = MUL_G_PREV;
      end
      ST_W: begin
        cmd.write_w = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = MUL_G_G;
      end
      ST_GX: begin
        cmd.calc_c = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_G_X;
      end
      ST_CD: begin
        cmd.load_acc = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_C_DLY;
      end
      ST_OUT:  cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ARV_ASSERT_NEXT(a_accept_route, clk, rst_n, in_valid && !in_stall, state_r == ST_GP || state_r == ST_OUT, "accepted sample went to a wrong step")
  `ARV_ASSERT_NOW(a_valid_source, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_OUT), "result shown outside the output step")
  `ARV_ASSERT_NEXT(a_out_leaves, clk, rst_n, state_r == ST_OUT && out_free, state_r == ST_IDLE && out_valid_r, "output step did not hand over its result")

endmodule

// ===== hw/rtl/arv_datapath.sv =====
// datapath of the allpass reverb section: config registers, delay line,
// shared multiplier, rounding and saturation; depends on arv_pkg, arv_ram
`include "allpass_reverb_section_macros.svh"

module arv_datapath
  import arv_pkg::*;
#(
  parameter int unsigned MAX_DELAY   = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last,
  input  arv_cmd_t                      cmd,
  output arv_sts_t                      sts
);

  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int unsigned CW  = $clog2(MAX_DELAY + 1);
  localparam int unsigned LW  = (CW > DLEN_W) ? CW : DLEN_W;
  localparam int unsigned BW  = (S > GAIN_W) ? S : GAIN_W;
  localparam int unsigned PW  = MUL_A_W + BW;
  localparam int unsigned WW  = S + 17;
  localparam int unsigned YW  = S + 32;
  localparam logic [CW-1:0] FULL   = CW'(MAX_DELAY);
  localparam logic [CW:0]   MAX_X  = (CW + 1)'(MAX_DELAY);
  localparam logic [LW-1:0] MAX_L  = LW'(MAX_DELAY);
  localparam logic [WW-1:0] W_HALF = WW'(1) << 14;
  localparam logic [YW-1:0] Y_HALF = YW'(1) << 29;

  // configuration registers
  logic                     enable_r;
  logic [DLEN_W-1:0]        dlen_r;
  logic signed [GAIN_W-1:0] gain_r;

  // loop state
  logic [AW-1:0]         wp_r;
  logic [CW-1:0]         fill_r;
  logic signed [S-1:0]   prev_r;

  // per-sample working registers
  logic signed [S-1:0]       x_r;
  logic                      last_r;
  logic                      bypass_r;
  logic                      rd_ok_r;
  logic signed [S-1:0]       delayed_r;
  logic signed [PW-1:0]      p_r;
  logic signed [MUL_A_W-1:0] c_r;
  logic signed [YW-1:0]      acc_r;
  logic signed [S-1:0]       out_sample_r;
  logic                      out_last_r;

  // combinational values
  logic [LW-1:0]             d_lim;
  logic [CW-1:0]             d_eff;
  logic [CW:0]               rd_sum;
  logic [CW:0]               rd_mod;
  logic [AW-1:0]             rd_addr;
  logic [S-1:0]              ram_rdata;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [WW-1:0]      w_sum;
  logic signed [WW-1:0]      w_sh;
  logic signed [S-1:0]       w_sat;
  logic signed [YW-1:0]      y_sum;
  logic signed [YW-1:0]      y_sh;
  logic signed [S-1:0]       y_sat;
  logic [AW-1:0]             wp_nxt;

  assign sts.enable = enable_r;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      dlen_r   <= DLEN_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:       enable_r <= cfg_wdata[0];
        REG_DELAY_LENGTH: dlen_r   <= cfg_wdata[DLEN_W-1:0];
        REG_LOOP_GAIN:    gain_r   <= signed'(cfg_wdata[GAIN_W-1:0]);
        default:          ;
      endcase
    end
  end

  // read address: zero length acts as one, length clamped to the store
  always_comb begin
    d_lim = (dlen_r == '0) ? LW'(1) : LW'(dlen_r);
    if (d_lim > MAX_L) begin
      d_lim = MAX_L;
    end
    d_eff  = CW'(d_lim);
    rd_sum = (CW + 1)'(wp_r) + MAX_X - (CW + 1)'(d_eff);
    rd_mod = (rd_sum >= MAX_X) ? (rd_sum - MAX_X) : rd_sum;
    rd_addr = AW'(rd_mod);
  end

  // write pointer wraps at the store depth
  assign wp_nxt = (CW'(wp_r) == FULL - CW'(1)) ? '0 : wp_r + AW'(1);

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_op)
      MUL_G_PREV: begin
        mul_a = MUL_A_W'(gain_r);
        mul_b = BW'(prev_r);
      end
      MUL_G_G: begin
        mul_a = MUL_A_W'(gain_r);
        mul_b = BW'(gain_r);
      end
      MUL_G_X: begin
        mul_a = MUL_A_W'(gain_r);
        mul_b = BW'(x_r);
      end
      MUL_C_DLY: begin
        mul_a = c_r;
        mul_b = BW'(delayed_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // w = x + g*prev, round half up from q.15, saturate
  always_comb begin
    w_sum = (WW'(x_r) <<< 15) + WW'(p_r) + signed'(W_HALF);
    w_sh  = w_sum >>> 15;
    if (w_sh[WW-1:S-1] == '0 || w_sh[WW-1:S-1] == '1) begin
      w_sat = w_sh[S-1:0];
    end else begin
      w_sat = w_sh[WW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end
  end

  // y = -g*x + (1-g*g)*delayed, round half up from q.30, saturate
  always_comb begin
    y_sum = acc_r + YW'(p_r) + signed'(Y_HALF);
    y_sh  = y_sum >>> 30;
    if (y_sh[YW-1:S-1] == '0 || y_sh[YW-1:S-1] == '1) begin
      y_sat = y_sh[S-1:0];
    end else begin
      y_sat = y_sh[YW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end
  end

  // delay store
  arv_ram #(
    .WIDTH (S),
    .DEPTH (MAX_DELAY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write_w),
    .waddr (wp_r),
    .wdata (w_sat),
    .re    (cmd.accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // loop state: entries below the fill count have been written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      prev_r <= '0;
    end else if (cmd.write_w) begin
      wp_r   <= wp_nxt;
      prev_r <= delayed_r;
      if (fill_r != FULL) begin
        fill_r <= fill_r + CW'(1);
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r      <= in_sample;
      last_r   <= in_last;
      bypass_r <= !enable_r;
      rd_ok_r  <= (CW'(rd_addr) < fill_r);
    end
  end

  // arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.take_read) begin
      delayed_r <= rd_ok_r ? signed'(ram_rdata) : '0;
    end
    if (cmd.mul_en) begin
      p_r <= PW'(mul_a) * PW'(mul_b);
    end
    if (cmd.calc_c) begin
      c_r <= signed'(ONE_Q30 - p_r[MUL_A_W-1:0]);
    end
    if (cmd.load_acc) begin
      acc_r <= (-YW'(p_r)) <<< 15;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= bypass_r ? x_r : y_sat;
      out_last_r   <= last_r;
    end
  end

  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  `ARV_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FULL, "fill count past store depth")
  `ARV_ASSERT_NOW(a_fill_tracks_wp, clk, rst_n, fill_r != FULL, CW'(wp_r) == fill_r, "write pointer and fill count disagree")
  `ARV_ASSERT_NEXT(a_fill_step, clk, rst_n, cmd.write_w && fill_r != FULL, fill_r == $past(fill_r) + CW'(1), "fill count missed a write")

endmodule

// ===== hw/rtl/allpass_reverb_section.sv =====
// allpass reverb section: one sample per transfer, result y = -g*x + (1-g*g)*delayed
// when enabled a sample passes ST_GP, ST_W, ST_GX and ST_CD before ST_OUT; disabled, only ST_OUT
// no new sample is taken until ST_OUT hands on the last; four steps use the shared multiplier
// reset: synchronous, clears control, config and loop state; the delay ram is not swept,
// entries not yet written since reset read as zero through a fill count
module allpass_reverb_section
  import arv_pkg::*;
#(
  parameter int unsigned MAX_DELAY   = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last
);

  arv_cmd_t cmd;
  arv_sts_t sts;

  // step sequencer
  arv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and delay line
  arv_datapath #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_sample),
    .in_last    (in_last),
    .out_sample (out_sample),
    .out_last   (out_last),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
